FILE: rtl/dsbh_pkg.sv
package dsbh_pkg;

  localparam int HASH_WIDTH = 64;
  localparam int BYTE_WIDTH = 8;
  localparam int COUNT_WIDTH = 31;
  localparam int STEP_WIDTH = $clog2(HASH_WIDTH);
  localparam int OUT_TDATA_WIDTH = ((COUNT_WIDTH + 7) / 8) * 8;

  localparam logic [HASH_WIDTH-1:0] HASH_SEED = HASH_WIDTH'(5381);
  localparam int HASH_SHIFT = 5;
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(1024);
  localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(HASH_WIDTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic update;   // fold a nonzero byte into the hash
    logic start;    // terminator taken: move hash to divider, reload seed
    logic step;     // one remainder bit
    logic emit;     // load the output register
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/dsbh_ctrl.sv
module dsbh_ctrl import dsbh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    is_term,
  input  status_t status,
  output logic    s_tready,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && is_term) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.last_step) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.update = s_tvalid && !is_term;
        cmd.start  = s_tvalid && is_term;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
      end
      ST_OUT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/dsbh_datapath.sv
module dsbh_datapath import dsbh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [BYTE_WIDTH-1:0]  char_byte,
  input  logic                   cfg_we,
  input  logic [COUNT_WIDTH-1:0] cfg_wdata,
  input  cmd_t                   cmd,
  input  logic                   m_tready,
  output logic                   is_term,
  output status_t                status,
  output logic                   m_tvalid,
  output logic [COUNT_WIDTH-1:0] bucket_index
);

  logic [HASH_WIDTH-1:0]  running_hash;
  logic [HASH_WIDTH-1:0]  dividend;
  logic [COUNT_WIDTH-1:0] rem;
  logic [STEP_WIDTH-1:0]  step_cnt;
  logic [COUNT_WIDTH-1:0] bucket_count;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH:0]   diff;
  logic [COUNT_WIDTH-1:0] rem_next;
  logic [HASH_WIDTH-1:0]  hash_next;

  assign is_term = (char_byte == '0);

  // hash * 33 + byte
  assign hash_next = (running_hash << HASH_SHIFT) + running_hash
                     + HASH_WIDTH'(char_byte);

  // restoring division, one quotient bit per cycle; zero divisor leaves the dividend's low 31 bits
  assign trial = {rem, dividend[HASH_WIDTH-1]};
  assign diff  = trial - {1'b0, bucket_count};
  always_comb begin
    if (trial >= {1'b0, bucket_count}) begin
      rem_next = diff[COUNT_WIDTH-1:0];
    end else begin
      rem_next = trial[COUNT_WIDTH-1:0];
    end
  end

  assign status.last_step = (step_cnt == '0);
  assign status.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= HASH_SEED;
      bucket_count <= COUNT_RESET;
      m_tvalid     <= 1'b0;
      step_cnt     <= '0;
    end else begin
      if (cfg_we) bucket_count <= cfg_wdata;
      if (cmd.update) begin
        running_hash <= hash_next;
      end else if (cmd.start) begin
        running_hash <= HASH_SEED;
      end
      if (cmd.start) begin
        step_cnt <= STEP_LAST;
      end else if (cmd.step) begin
        step_cnt <= step_cnt - 1'b1;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dividend <= running_hash;
      rem      <= '0;
    end else if (cmd.step) begin
      dividend <= dividend << 1;
      rem      <= rem_next;
    end
    if (cmd.emit) bucket_index <= rem;
  end

endmodule

FILE: rtl/djb2_string_bucket_hash_top.sv
// channel  | signals                     | content
// s_       | s_tvalid s_tready s_tdata   | one string byte, zero ends the string
// m_       | m_tvalid m_tready m_tdata   | bucket index, one per string
// cfg_     | cfg_we cfg_wdata            | bucket count (reset 1024)
//
// while idle a nonzero byte is taken every cycle, the hash update is a 64-bit shift and add
// a zero byte starts the bit-serial remainder unit, one step per hash bit,
// then the output register is loaded, and only after that is the next byte taken,
// later if the output register is still full
// rst is synchronous, clears the hash to 5381 and the bucket count to 1024
module djb2_string_bucket_hash_top import dsbh_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [BYTE_WIDTH-1:0]      s_tdata,   // [7:0] char_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata,   // [30:0] bucket_index, [31] zero
  input  logic                       cfg_we,
  input  logic [COUNT_WIDTH-1:0]     cfg_wdata
);

  cmd_t                   cmd;
  status_t                status;
  logic                   is_term;
  logic [COUNT_WIDTH-1:0] bucket_index;

  dsbh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .is_term  (is_term),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  dsbh_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .char_byte    (s_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .m_tready     (m_tready),
    .is_term      (is_term),
    .status       (status),
    .m_tvalid     (m_tvalid),
    .bucket_index (bucket_index)
  );

  assign m_tdata = OUT_TDATA_WIDTH'(bucket_index);

endmodule
